// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lzdw_pkg.sv
package lzdw_pkg;

    localparam int WINDOW_DEPTH  = 4096;
    localparam int ADDR_W        = 12;
    localparam int LEN_W         = 8;
    localparam int CNT_W         = 3;
    localparam int BYTE_W        = 8;
    localparam int OUT_LEN_W     = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CMD_Q_DEPTH   = 4;

    localparam int WIN_LARGE     = 4096;
    localparam int WIN_SMALL     = 512;
    localparam int LEN_MAX_LARGE = 18;
    localparam int LEN_MAX_SMALL = 130;

    localparam logic [LEN_W-1:0]     MIN_MATCH     = 8'd3;
    localparam logic [BYTE_W-1:0]    FLAG_FILL     = 8'hff;
    localparam int                   FLAG_MARK_BIT = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LIT,
        OP_COPY
    } t_op;

    typedef struct packed {
        logic                start;
        t_op                 op;
        logic [BYTE_W-1:0]   data;
        logic [ADDR_W-1:0]   offset;
        logic [LEN_W-1:0]    length;
    } t_cmd;

endpackage

// File: hw/rtl/lzdw_ram.sv
module lzdw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/lzdw_front.sv
module lzdw_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_window_mode,
    input  logic                        i_s_valid,
    input  logic [lzdw_pkg::BYTE_W-1:0] i_s_data,
    input  logic                        i_s_start,
    output logic                        o_s_ready,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output lzdw_pkg::t_cmd              o_q_cmd
);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_OFF_HI
    } t_phase;

    t_phase                      r_phase, n_phase, c_phase;
    logic [15:0]                 r_fs, n_fs, c_fs, c_fs_t;
    logic [lzdw_pkg::BYTE_W-1:0] r_lo, n_lo, c_lo;
    logic                        c_accept;
    logic                        c_tok;
    lzdw_pkg::t_op               c_op;
    logic [lzdw_pkg::ADDR_W-1:0] c_offset;
    logic [lzdw_pkg::LEN_W-1:0]  c_len;

    assign o_s_ready = !i_q_full;
    assign c_accept  = i_s_valid && !i_q_full;

    always_comb begin
        c_fs    = i_s_start ? 16'd0 : r_fs;
        c_phase = i_s_start ? PH_FLAG : r_phase;
        c_lo    = i_s_start ? '0 : r_lo;
        c_fs_t  = c_fs;
        c_tok   = 1'b0;
        c_op    = lzdw_pkg::OP_NONE;
        n_fs    = c_fs;
        n_lo    = c_lo;
        n_phase = c_phase;
        case (c_phase)
            PH_FLAG: begin
                c_fs_t = c_fs >> 1;
                n_fs   = c_fs_t;
                if (c_fs_t[lzdw_pkg::FLAG_MARK_BIT]) begin
                    c_tok = 1'b1;
                end else begin
                    n_fs    = {lzdw_pkg::FLAG_FILL, i_s_data};
                    n_phase = PH_TOKEN;
                end
            end
            PH_TOKEN: begin
                c_tok = 1'b1;
            end
            PH_OFF_HI: begin
                c_op    = lzdw_pkg::OP_COPY;
                n_phase = PH_FLAG;
            end
            default: begin
                n_phase = PH_FLAG;
            end
        endcase
        if (c_tok) begin
            if (c_fs_t[0]) begin
                c_op    = lzdw_pkg::OP_LIT;
                n_phase = PH_FLAG;
            end else begin
                n_lo    = i_s_data;
                n_phase = PH_OFF_HI;
            end
        end
    end

    always_comb begin
        if (i_window_mode) begin
            c_offset = {i_s_data[7:4], c_lo};
            c_len    = {4'd0, i_s_data[3:0]} + lzdw_pkg::MIN_MATCH;
        end else begin
            c_offset = {3'd0, i_s_data[7], c_lo};
            c_len    = {1'b0, i_s_data[6:0]} + lzdw_pkg::MIN_MATCH;
        end
    end

    assign o_q_push       = c_accept && (i_s_start || c_op != lzdw_pkg::OP_NONE);
    assign o_q_cmd.start  = i_s_start;
    assign o_q_cmd.op     = c_op;
    assign o_q_cmd.data   = i_s_data;
    assign o_q_cmd.offset = c_offset;
    assign o_q_cmd.length = c_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_fs    <= 16'd0;
            r_lo    <= '0;
        end else if (c_accept) begin
            r_phase <= n_phase;
            r_fs    <= n_fs;
            r_lo    <= n_lo;
        end
    end

endmodule

// File: hw/rtl/lzdw_cmd_fifo.sv
module lzdw_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lzdw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lzdw_pkg::t_cmd o_cmd
);

    localparam int AW = $clog2(lzdw_pkg::CMD_Q_DEPTH);
    localparam int CW = $clog2(lzdw_pkg::CMD_Q_DEPTH + 1);

    lzdw_pkg::t_cmd r_mem [lzdw_pkg::CMD_Q_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           c_push;
    logic           c_pop;

    assign o_full  = (r_cnt == CW'(lzdw_pkg::CMD_Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign c_push  = i_push && !o_full;
    assign c_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (c_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            case ({c_push, c_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hw/rtl/lzdw_back.sv
module lzdw_back #(
    parameter int BYTES_PER_RESULT = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_window_mode,
    input  logic [lzdw_pkg::OUT_LEN_W-1:0]         i_output_length,
    input  logic                                   i_q_valid,
    input  lzdw_pkg::t_cmd                         i_q_cmd,
    output logic                                   o_q_pop,
    output logic                                   o_m_valid,
    input  logic                                   i_m_ready,
    output logic [lzdw_pkg::BYTE_W*BYTES_PER_RESULT-1:0] o_m_bytes,
    output logic [lzdw_pkg::CNT_W-1:0]             o_m_cnt,
    output logic                                   o_m_last,
    output logic                                   o_m_done
);

    localparam int PN_W = $clog2(BYTES_PER_RESULT);
    localparam int AW   = lzdw_pkg::ADDR_W;
    localparam int BW   = lzdw_pkg::BYTE_W;
    localparam int LW   = lzdw_pkg::LEN_W;
    localparam int RW   = lzdw_pkg::OUT_LEN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_EXEC,
        ST_COPY
    } t_state;

    t_state          r_state, n_state;
    lzdw_pkg::t_cmd  r_cmd, n_cmd;
    logic [AW-1:0]   r_wp, n_wp;
    logic [RW-1:0]   r_rem, n_rem;
    logic [AW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_rd_addr, n_rd_addr;
    logic [LW-1:0]   r_issue_left, n_issue_left;
    logic [LW-1:0]   r_cons_left, n_cons_left;
    logic            r_b_valid, n_b_valid;
    logic            r_byp, n_byp;
    logic [BW-1:0]   r_byp_data, n_byp_data;
    logic [BW-1:0]   r_pack [BYTES_PER_RESULT];
    logic [BW-1:0]   n_pack [BYTES_PER_RESULT];
    logic [PN_W-1:0] r_pack_n, n_pack_n;
    logic            r_out_valid, n_out_valid;
    logic [BW-1:0]   r_out_bytes [BYTES_PER_RESULT];
    logic [BW-1:0]   n_out_bytes [BYTES_PER_RESULT];
    logic [lzdw_pkg::CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic            r_out_last, n_out_last;
    logic            r_out_done, n_out_done;

    logic [AW-1:0]   c_win_mask;
    logic [AW-1:0]   c_wp_addr;
    logic [BW-1:0]   w_ram_rdata;
    logic [BW-1:0]   c_rd_eff;
    logic            c_want;
    logic [BW-1:0]   c_byte;
    logic            c_last;
    logic            c_flush;
    logic            c_out_free;
    logic            c_go;
    logic            c_stall;
    logic            c_re;
    logic            c_we;
    logic [AW-1:0]   c_waddr;
    logic [BW-1:0]   c_wdata;
    logic [RW-1:0]   c_rem_dec;
    logic [LW-1:0]   c_copy_n;

    lzdw_ram #(
        .WIDTH(BW),
        .DEPTH(lzdw_pkg::WINDOW_DEPTH)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_re   (c_re),
        .i_raddr(r_rd_addr),
        .o_rdata(w_ram_rdata)
    );

    always_comb begin
        c_win_mask = i_window_mode ? AW'(lzdw_pkg::WIN_LARGE - 1)
                                   : AW'(lzdw_pkg::WIN_SMALL - 1);
        c_wp_addr  = r_wp & c_win_mask;
        c_rd_eff   = r_byp ? r_byp_data : w_ram_rdata;
        c_want     = (r_state == ST_EXEC && r_cmd.op == lzdw_pkg::OP_LIT && r_rem != '0)
                  || (r_state == ST_COPY && r_b_valid);
        c_byte     = (r_state == ST_COPY) ? c_rd_eff : r_cmd.data;
        c_last     = (r_state == ST_COPY) ? (r_cons_left == LW'(1)) : 1'b1;
        c_flush    = c_want && (c_last || r_pack_n == PN_W'(BYTES_PER_RESULT - 1));
        c_out_free = !r_out_valid || i_m_ready;
        c_go       = c_want && (!c_flush || c_out_free);
        c_stall    = c_want && !c_go;
        c_re       = (r_state == ST_COPY) && !c_stall && (r_issue_left != '0);
        c_we       = (r_state == ST_CLEAR) || c_go;
        c_waddr    = (r_state == ST_CLEAR) ? r_clr : c_wp_addr;
        c_wdata    = (r_state == ST_CLEAR) ? '0 : c_byte;
        c_rem_dec  = r_rem - RW'(1);
        c_copy_n   = (r_rem < RW'(r_cmd.length)) ? r_rem[LW-1:0] : r_cmd.length;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_wp         = r_wp;
        n_rem        = r_rem;
        n_clr        = r_clr;
        n_rd_addr    = r_rd_addr;
        n_issue_left = r_issue_left;
        n_cons_left  = r_cons_left;
        n_b_valid    = r_b_valid;
        n_byp        = r_byp;
        n_byp_data   = r_byp_data;
        n_pack       = r_pack;
        n_pack_n     = r_pack_n;
        n_out_valid  = r_out_valid;
        n_out_bytes  = r_out_bytes;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;
        o_q_pop      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    if (i_q_cmd.start) begin
                        n_wp    = i_window_mode
                                ? AW'(lzdw_pkg::WIN_LARGE - lzdw_pkg::LEN_MAX_LARGE)
                                : AW'(lzdw_pkg::WIN_SMALL - lzdw_pkg::LEN_MAX_SMALL);
                        n_rem   = i_output_length;
                        n_clr   = '0;
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_b_valid = 1'b0;
                n_byp     = 1'b0;
                case (r_cmd.op)
                    lzdw_pkg::OP_LIT: begin
                        if (r_rem == '0 || c_go) begin
                            n_state = ST_IDLE;
                        end
                    end
                    lzdw_pkg::OP_COPY: begin
                        if (r_rem == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_rd_addr    = r_cmd.offset & c_win_mask;
                            n_issue_left = c_copy_n;
                            n_cons_left  = c_copy_n;
                            n_state      = ST_COPY;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_COPY: begin
                if (!c_stall) begin
                    n_b_valid = c_re;
                end
                if (c_re) begin
                    n_rd_addr    = (r_rd_addr + AW'(1)) & c_win_mask;
                    n_issue_left = r_issue_left - LW'(1);
                    n_byp        = c_we && (c_waddr == r_rd_addr);
                    n_byp_data   = c_wdata;
                end
                if (c_go) begin
                    n_cons_left = r_cons_left - LW'(1);
                    if (c_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (c_flush && c_go) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end

        if (c_go) begin
            n_wp  = (r_wp + AW'(1)) & c_win_mask;
            n_rem = c_rem_dec;
            if (c_flush) begin
                for (int j = 0; j < BYTES_PER_RESULT; j++) begin
                    if (PN_W'(j) < r_pack_n) begin
                        n_out_bytes[j] = r_pack[j];
                    end else if (PN_W'(j) == r_pack_n) begin
                        n_out_bytes[j] = c_byte;
                    end else begin
                        n_out_bytes[j] = '0;
                    end
                end
                n_out_cnt  = lzdw_pkg::CNT_W'(r_pack_n) + lzdw_pkg::CNT_W'(1);
                n_out_last = c_last;
                n_out_done = c_last && (c_rem_dec == '0);
                n_pack_n   = '0;
            end else begin
                n_pack[r_pack_n] = c_byte;
                n_pack_n         = r_pack_n + PN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= AW'(lzdw_pkg::WIN_LARGE - lzdw_pkg::LEN_MAX_LARGE);
            r_rem       <= '0;
            r_b_valid   <= 1'b0;
            r_byp       <= 1'b0;
            r_pack_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rem       <= n_rem;
            r_b_valid   <= n_b_valid;
            r_byp       <= n_byp;
            r_pack_n    <= n_pack_n;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_clr        <= n_clr;
        r_rd_addr    <= n_rd_addr;
        r_issue_left <= n_issue_left;
        r_cons_left  <= n_cons_left;
        r_byp_data   <= n_byp_data;
        r_pack       <= n_pack;
        r_out_bytes  <= n_out_bytes;
        r_out_cnt    <= n_out_cnt;
        r_out_last   <= n_out_last;
        r_out_done   <= n_out_done;
    end

    always_comb begin
        for (int j = 0; j < BYTES_PER_RESULT; j++) begin
            o_m_bytes[j*BW +: BW] = r_out_bytes[j];
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_cnt   = r_out_cnt;
    assign o_m_last  = r_out_last;
    assign o_m_done  = r_out_done;

endmodule

// File: hw/rtl/lzss_dual_window_decompressor.sv
// Flow: the front end queues a command for each literal, copy or stream start; the back end
//   pops it, and a copy of n bytes is read from the window, bytes packed per result as they are read.
// The command queue takes new requests while earlier ones run; one window byte per cycle unless the output stalls.
// A request with start_of_stream adds a clearing pass over all 4096 window entries.
// Reset (synchronous, active low) clears control state and registers; the window is
//   not touched until a stream start clears it.
`include "assert_macros.svh"

module lzss_dual_window_decompressor #(
    parameter int BYTES_PER_RESULT = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [lzdw_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [lzdw_pkg::OUT_LEN_W-1:0]       i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // data_byte
    input  logic [7:0]                           s_axis_tdata,
    // start_of_stream
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_byte0 .. out_byte(N-1), valid_count, zero fill
    output logic [((8*BYTES_PER_RESULT + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                 m_axis_tlast,
    // stream_done
    output logic [0:0]                           m_axis_tuser
);

    localparam int DATA_W = 8 * BYTES_PER_RESULT;
    localparam int TD_W   = ((DATA_W + lzdw_pkg::CNT_W + 7) / 8) * 8;
    localparam int PAD_W  = TD_W - DATA_W - lzdw_pkg::CNT_W;

    logic                             r_window_mode;
    logic [lzdw_pkg::OUT_LEN_W-1:0]   r_output_length;
    logic                             w_q_push;
    lzdw_pkg::t_cmd                   w_q_wcmd;
    logic                             w_q_full;
    logic                             w_q_pop;
    logic                             w_q_valid;
    lzdw_pkg::t_cmd                   w_q_rcmd;
    logic [DATA_W-1:0]                w_m_bytes;
    logic [lzdw_pkg::CNT_W-1:0]       w_m_cnt;
    logic                             w_m_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mode   <= 1'b1;
            r_output_length <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                lzdw_pkg::CFG_WINDOW_MODE:   r_window_mode   <= i_cfg_wdata[0];
                lzdw_pkg::CFG_OUTPUT_LENGTH: r_output_length <= i_cfg_wdata;
                default: begin
                    r_window_mode   <= r_window_mode;
                    r_output_length <= r_output_length;
                end
            endcase
        end
    end

    lzdw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window_mode(r_window_mode),
        .i_s_valid    (s_axis_tvalid),
        .i_s_data     (s_axis_tdata),
        .i_s_start    (s_axis_tuser[0]),
        .o_s_ready    (s_axis_tready),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_cmd      (w_q_wcmd)
    );

    lzdw_cmd_fifo u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_cmd  (w_q_wcmd),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_valid(w_q_valid),
        .o_cmd  (w_q_rcmd)
    );

    lzdw_back #(
        .BYTES_PER_RESULT(BYTES_PER_RESULT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_mode  (r_window_mode),
        .i_output_length(r_output_length),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_rcmd),
        .o_q_pop        (w_q_pop),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_m_bytes      (w_m_bytes),
        .o_m_cnt        (w_m_cnt),
        .o_m_last       (m_axis_tlast),
        .o_m_done       (w_m_done)
    );

    assign m_axis_tdata    = {{PAD_W{1'b0}}, w_m_cnt, w_m_bytes};
    assign m_axis_tuser[0] = w_m_done;

    `ASSERT_IMP(a_done_ends_run, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "stream done on a result that does not end its run")
    `ASSERT_NXT(a_reset_clears_out, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid, "result valid right after reset")
    `ASSERT_IMP(a_full_q_has_cmd, i_clk, i_rst_n, w_q_full, w_q_valid, "command queue full but empty")

endmodule

// File: tb/lzss_dual_window_decompressor_checker.sv
`timescale 1ns / 100ps

module lzss_dual_window_decompressor_checker
    import lzdw_pkg::*;
#(
    parameter int BPR   = 4,
    parameter int OUT_W = ((8 * 4 + 3 + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [OUT_LEN_W-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // data_byte
    input  logic [7:0]           s_axis_tdata,
    // start_of_stream
    input  logic [0:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_byte0 .. out_byte3, valid_count, zero fill
    input  logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 m_axis_tlast,
    // stream_done
    input  logic [0:0]           m_axis_tuser,
    output int                   o_error_count,
    output int                   o_pending
);

    typedef enum logic [1:0] {
        AWAIT_FLAG,
        AWAIT_TOKEN,
        AWAIT_OFFSET_HIGH
    } t_token_phase;

    typedef struct packed {
        logic               done;
        logic               last;
        logic [CNT_W-1:0]   count;
        logic [BPR*8-1:0]   bytes;
    } t_word;

    t_word                  expected_words [$];
    int                     error_count = 0;

    logic                   large_window;
    logic [OUT_LEN_W-1:0]   length_reg;
    logic [BYTE_W-1:0]      history [WINDOW_DEPTH];
    logic [ADDR_W-1:0]      wr_pos;
    logic [15:0]            flags;
    t_token_phase           phase;
    logic [BYTE_W-1:0]      offset_low;
    logic [OUT_LEN_W-1:0]   remaining;
    logic                   finished;
    logic [BYTE_W-1:0]      run_bytes [LEN_MAX_SMALL];
    int                     run_len;

    assign o_error_count = error_count;

    function automatic logic [ADDR_W-1:0] win_mask();
        return large_window ? ADDR_W'(WIN_LARGE - 1) : ADDR_W'(WIN_SMALL - 1);
    endfunction

    task automatic clear_history();
        int i;
        for (i = 0; i < WINDOW_DEPTH; i++) history[i] = '0;
    endtask

    task automatic reset_state();
        large_window = 1'b1;
        length_reg   = '0;
        clear_history();
        wr_pos       = ADDR_W'(WIN_LARGE - LEN_MAX_LARGE);
        flags        = '0;
        phase        = AWAIT_FLAG;
        offset_low   = '0;
        remaining    = '0;
        finished     = 1'b0;
        run_len      = 0;
        expected_words.delete();
    endtask

    task automatic emit_byte(input logic [BYTE_W-1:0] value);
        if (remaining == 0 || run_len >= LEN_MAX_SMALL) return;
        run_bytes[run_len] = value;
        run_len++;
        history[wr_pos & win_mask()] = value;
        wr_pos = (wr_pos + 1'b1) & win_mask();
        remaining--;
        if (remaining == 0) finished = 1'b1;
    endtask

    task automatic decode_request(input logic [BYTE_W-1:0] c, input logic sos);
        logic [ADDR_W-1:0] offset;
        int                length;
        int                k;
        int                n_words;
        int                cnt;
        int                r;
        int                j;
        t_word             w;
        if (sos) begin
            clear_history();
            wr_pos     = large_window ? ADDR_W'(WIN_LARGE - LEN_MAX_LARGE)
                                      : ADDR_W'(WIN_SMALL - LEN_MAX_SMALL);
            flags      = '0;
            phase      = AWAIT_FLAG;
            offset_low = '0;
            remaining  = length_reg;
            finished   = (length_reg == 0);
        end
        if (remaining == 0) return;
        run_len = 0;
        if (phase == AWAIT_FLAG) begin
            flags = flags >> 1;
            if (!flags[FLAG_MARK_BIT]) begin
                flags = {FLAG_FILL, c};
                phase = AWAIT_TOKEN;
                return;
            end
            phase = AWAIT_TOKEN;
        end
        if (phase == AWAIT_TOKEN) begin
            if (flags[0]) begin
                emit_byte(c);
                phase = AWAIT_FLAG;
            end else begin
                offset_low = c;
                phase      = AWAIT_OFFSET_HIGH;
            end
        end else begin
            if (large_window) begin
                offset = {c[7:4], offset_low};
                length = int'(c[3:0]) + int'(MIN_MATCH);
            end else begin
                offset = {3'b000, c[7], offset_low};
                length = int'(c[6:0]) + int'(MIN_MATCH);
            end
            for (k = 0; k < length && remaining != 0; k++) begin
                emit_byte(history[(offset + ADDR_W'(k)) & win_mask()]);
            end
            phase = AWAIT_FLAG;
        end
        n_words = (run_len + BPR - 1) / BPR;
        for (r = 0; r < n_words; r++) begin
            cnt = run_len - r * BPR;
            if (cnt > BPR) cnt = BPR;
            w = '0;
            for (j = 0; j < cnt; j++) w.bytes[j*8 +: 8] = run_bytes[r * BPR + j];
            w.count = CNT_W'(cnt);
            w.last  = (r == n_words - 1);
            w.done  = w.last && finished;
            expected_words.push_back(w);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_word();
        t_word w;
        int    j;
        if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: result with none expected, tdata %h tlast %b tuser %b",
                     $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            return;
        end
        w = expected_words.pop_front();
        for (j = 0; j < BPR; j++) begin
            compare_field($sformatf("out_byte%0d", j), w.bytes[j*8 +: 8],
                          m_axis_tdata[j*8 +: 8]);
        end
        compare_field("valid_count", w.count, m_axis_tdata[BPR*8 +: CNT_W]);
        compare_field("zero fill", '0, m_axis_tdata[OUT_W-1:BPR*8+CNT_W]);
        compare_field("last_of_run", w.last, m_axis_tlast);
        compare_field("stream_done", w.done, m_axis_tuser[0]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_addr)
                    CFG_WINDOW_MODE:   large_window = i_cfg_wdata[0];
                    CFG_OUTPUT_LENGTH: length_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) decode_request(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready) check_word();
        end
        o_pending <= expected_words.size();
    end

endmodule

// File: tb/lzss_dual_window_decompressor_tb.sv
`timescale 1ns / 100ps

module lzss_dual_window_decompressor_tb;

    import lzdw_pkg::*;

    localparam int BPR          = 4;
    localparam int OUT_W        = ((8 * BPR + CNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 4200;
    localparam int RANDOM_ITEMS = 480;
    localparam int SIDE_SEND    = 0;
    localparam int SIDE_RECV    = 1;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr    = CFG_WINDOW_MODE;
    logic [OUT_LEN_W-1:0]   i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       m_axis_tdata;
    logic                   m_axis_tlast;
    logic [0:0]             m_axis_tuser;

    int                     error_count;
    int                     pending;
    int                     cycle_count = 0;
    int                     calm_left [2] = '{0, 0};
    int                     rx_hold = 0;
    logic                   gen_large = 1'b1;
    int                     gen_pos = 0;
    int                     stream_items = 0;
    int                     starts_sent = 0;
    int                     budget;
    logic [OUT_LEN_W-1:0]   out_len;

    lzss_dual_window_decompressor #(
        .BYTES_PER_RESULT (BPR)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    lzss_dual_window_decompressor_checker #(
        .BPR   (BPR),
        .OUT_W (OUT_W)
    ) u_decode_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lzss_dual_window_decompressor test failed");
            $finish;
        end
    end

    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm_left[side] = $urandom_range(16, 64);
        return $urandom_range(0, 16);
    endfunction

    // stall the result side for a drawn number of cycles after each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) rx_hold = draw_gap(SIDE_RECV);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic sos);
        int gap;
        gap = draw_gap(SIDE_SEND);
        if (sos) starts_sent++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= sos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OUT_LEN_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_window(input logic wide);
        write_reg(CFG_WINDOW_MODE, OUT_LEN_W'(wide));
        gen_large = wide;
    endtask

    // hold until every expected result is back, then let the block settle
    task automatic end_phase();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES * (starts_sent + 1)) @(posedge i_clk);
        starts_sent = 0;
    endtask

    task automatic send_stream(input logic restart, input int n_bytes);
        logic [7:0]        flag_byte;
        logic [ADDR_W-1:0] wmask;
        logic [ADDR_W-1:0] offset;
        int                sent;
        int                b;
        int                len;
        sent  = 0;
        wmask = gen_large ? ADDR_W'(WIN_LARGE - 1) : ADDR_W'(WIN_SMALL - 1);
        if (restart) gen_pos = gen_large ? WIN_LARGE - LEN_MAX_LARGE : WIN_SMALL - LEN_MAX_SMALL;
        while (sent < n_bytes) begin
            flag_byte = 8'($urandom);
            send_byte(flag_byte, restart && sent == 0);
            sent++;
            for (b = 0; b < 8 && sent < n_bytes; b++) begin
                if (flag_byte[b]) begin
                    send_byte(8'($urandom), 1'b0);
                    sent++;
                    gen_pos++;
                end else begin
                    len = gen_large ? $urandom_range(3, LEN_MAX_LARGE)
                                    : $urandom_range(3, LEN_MAX_SMALL);
                    if ($urandom_range(0, 3) == 0) offset = ADDR_W'($urandom);
                    else offset = ADDR_W'(gen_pos - $urandom_range(1, 40));
                    offset &= wmask;
                    send_byte(offset[7:0], 1'b0);
                    if (gen_large) send_byte({offset[11:8], 4'(len - int'(MIN_MATCH))}, 1'b0);
                    else send_byte({offset[8], 7'(len - int'(MIN_MATCH))}, 1'b0);
                    sent += 2;
                    gen_pos += len;
                end
            end
        end
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing to produce yet: drop these
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        end_phase();

        set_window(1'b1);
        write_reg(CFG_OUTPUT_LENGTH, 32'd40);
        send_byte(8'h05, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hEE, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h77, 1'b0);
        end_phase();

        set_window(1'b0);
        write_reg(CFG_OUTPUT_LENGTH, 32'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        end_phase();

        write_reg(CFG_OUTPUT_LENGTH, 32'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        end_phase();

        write_reg(CFG_OUTPUT_LENGTH, 32'hFFFF_FFFF);
        send_byte(8'h02, 1'b1);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b0);
        end_phase();

        // switch window size mid-stream
        set_window(1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);

        while (stream_items < RANDOM_ITEMS) begin
            end_phase();
            set_window(1'($urandom_range(0, 1)));
            case ($urandom_range(0, 7))
                0:       out_len = $urandom_range(1, 24);
                1:       out_len = 32'hFFFF_FFFF;
                default: out_len = gen_large ? $urandom_range(300, 1500)
                                             : $urandom_range(1500, 6000);
            endcase
            write_reg(CFG_OUTPUT_LENGTH, out_len);
            budget = $urandom_range(16, 64);
            send_stream($urandom_range(0, 5) != 0, budget);
            stream_items += budget;
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(2, 8));
        end
        end_phase();

        if (error_count == 0) begin
            $display("lzss_dual_window_decompressor test passed");
        end else begin
            $display("lzss_dual_window_decompressor test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lzdw_pkg.sv
hw/rtl/lzdw_ram.sv
hw/rtl/lzdw_front.sv
hw/rtl/lzdw_cmd_fifo.sv
hw/rtl/lzdw_back.sv
hw/rtl/lzss_dual_window_decompressor.sv
tb/lzss_dual_window_decompressor_checker.sv
tb/lzss_dual_window_decompressor_tb.sv
